### rtl/assert_macros.svh
// Assertion shorthands for the device table RTL.
// Expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define KDT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Expression must never be true outside reset.
`define KDT_ASSERT_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

### rtl/kdt_pkg.sv
// Shared types and codes for the keyed device table.
// No dependencies; used by kdt_cell and keyed_device_table.
`default_nettype none

package kdt_pkg;

    localparam int KEY_BITS          = 48;
    localparam int OUT_HANDLE_BITS   = 16;
    localparam int COUNT_FIELD_BITS  = 6;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_FIND = 1'b1;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // Request as it walks the chain of cells.
    typedef struct packed {
        logic                valid;
        logic                action;
        logic                hit;
        logic                appended;
        logic [KEY_BITS-1:0] key;
    } kdt_token_t;

endpackage

`default_nettype wire

### rtl/kdt_cell.sv
// One table entry: stores a key and handle, checks a passing request against them.
// Depends on kdt_pkg.
`default_nettype none

module kdt_cell #(
    parameter int INDEX       = 0,
    parameter int CNT_BITS    = 6,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [CNT_BITS-1:0]    used_count,
    input  wire kdt_pkg::kdt_token_t    tok_in,
    input  wire logic [HANDLE_BITS-1:0] hnd_in,
    input  wire logic [HANDLE_BITS-1:0] fnd_in,
    output kdt_pkg::kdt_token_t         tok_out,
    output logic      [HANDLE_BITS-1:0] hnd_out,
    output logic      [HANDLE_BITS-1:0] fnd_out
);

    logic [kdt_pkg::KEY_BITS-1:0] key_reg;
    logic [HANDLE_BITS-1:0]       handle_reg;
    kdt_pkg::kdt_token_t          tok_reg;
    kdt_pkg::kdt_token_t          tok_next;
    logic [HANDLE_BITS-1:0]       hnd_reg;
    logic [HANDLE_BITS-1:0]       fnd_reg;
    logic [HANDLE_BITS-1:0]       fnd_next;
    logic                         in_use;
    logic                         match;
    logic                         append_here;

    assign in_use = CNT_BITS'(INDEX) < used_count;
    assign match  = tok_in.valid && in_use && !tok_in.hit && (tok_in.key == key_reg);
    // First free slot: every valid entry has already been checked upstream.
    assign append_here = tok_in.valid && !tok_in.hit && (tok_in.action == kdt_pkg::ACT_ADD)
                         && (CNT_BITS'(INDEX) == used_count);

    always_comb
    begin
        tok_next          = tok_in;
        tok_next.hit      = tok_in.hit | match;
        tok_next.appended = tok_in.appended | append_here;
        fnd_next          = fnd_in;
        if (match && tok_in.action == kdt_pkg::ACT_FIND)
        begin
            fnd_next = handle_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (match && tok_in.action == kdt_pkg::ACT_ADD)
        begin
            handle_reg <= hnd_in;
        end
        else if (append_here)
        begin
            key_reg    <= tok_in.key;
            handle_reg <= hnd_in;
        end
        hnd_reg <= hnd_in;
        fnd_reg <= fnd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign hnd_out = hnd_reg;
    assign fnd_out = fnd_reg;

endmodule

`default_nettype wire

### rtl/keyed_device_table.sv
// Keyed device table top level: chain of kdt_cell entries plus result registers.
// Depends on kdt_pkg, kdt_cell and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries action, key_address and
//   device_handle. Output channel (out_valid/out_ready) carries status,
//   found_handle and entry_count, one result per request, in order.
//   A request walks a row of DEPTH cells, one cell per cycle; each cell
//   compares the key with its entry, updates or reads its handle, and the
//   first free cell takes the key when an add misses. One request is in
//   the chain at a time. in_ready stays low from accept until the result
//   moves into the output register. A finished result waits in a holding
//   register, so one more request can walk the chain while the receiver
//   stalls; after that, in_ready stays low until the receiver takes the
//   output.
//   Reset empties the table (entry count zero) and drops all requests in
//   flight; no clearing pass is needed.
`default_nettype none

`include "assert_macros.svh"

module keyed_device_table #(
    parameter int DEPTH       = 32,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic                                    action,
    input  wire logic [kdt_pkg::KEY_BITS-1:0]            key_address,
    input  wire logic [kdt_pkg::OUT_HANDLE_BITS-1:0]     device_handle,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic [2:0]                                   status,
    output logic [kdt_pkg::OUT_HANDLE_BITS-1:0]          found_handle,
    output logic [kdt_pkg::COUNT_FIELD_BITS-1:0]         entry_count
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int OHB      = kdt_pkg::OUT_HANDLE_BITS;
    localparam int CFB      = kdt_pkg::COUNT_FIELD_BITS;

    kdt_pkg::kdt_token_t    tok   [DEPTH+1];
    logic [HANDLE_BITS-1:0] hnd   [DEPTH+1];
    logic [HANDLE_BITS-1:0] fnd   [DEPTH+1];

    logic                   busy_reg;
    logic [CNT_BITS-1:0]    count_reg;
    logic [CNT_BITS-1:0]    count_next;
    logic                   done_valid_reg;
    kdt_pkg::status_t       done_status_reg;
    logic [OHB-1:0]         done_found_reg;
    logic [CFB-1:0]         done_count_reg;
    logic                   out_valid_reg;
    kdt_pkg::status_t       out_status_reg;
    logic [OHB-1:0]         out_found_reg;
    logic [CFB-1:0]         out_count_reg;

    logic                   accept;
    logic                   move_out;
    kdt_pkg::kdt_token_t    tail;
    kdt_pkg::status_t       tail_status;
    logic [OHB-1:0]         tail_found;
    logic [CFB-1:0]         tail_count;
    logic [HANDLE_BITS+OHB-1:0] in_handle_ext;
    logic [HANDLE_BITS+OHB-1:0] found_ext;
    logic [CNT_BITS+CFB-1:0]    count_ext;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign move_out = done_valid_reg && (!out_valid_reg || out_ready);

    // Fit the 16-bit handle field to the stored width.
    assign in_handle_ext = {{HANDLE_BITS{1'b0}}, device_handle};

    // Fields in order: valid, action, hit, appended, key.
    assign tok[0] = {accept, action, 1'b0, 1'b0, key_address};
    assign hnd[0] = in_handle_ext[HANDLE_BITS-1:0];
    assign fnd[0] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        kdt_cell #(
            .INDEX       (i),
            .CNT_BITS    (CNT_BITS),
            .HANDLE_BITS (HANDLE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .used_count (count_reg),
            .tok_in     (tok[i]),
            .hnd_in     (hnd[i]),
            .fnd_in     (fnd[i]),
            .tok_out    (tok[i+1]),
            .hnd_out    (hnd[i+1]),
            .fnd_out    (fnd[i+1])
        );
    end

    assign tail       = tok[DEPTH];
    assign count_next = count_reg + CNT_BITS'(tail.appended);
    assign found_ext  = {{OHB{1'b0}}, fnd[DEPTH]};
    assign count_ext  = {{CFB{1'b0}}, count_next};
    assign tail_found = found_ext[OHB-1:0];
    assign tail_count = count_ext[CFB-1:0];

    always_comb
    begin
        if (tail.action == kdt_pkg::ACT_ADD)
        begin
            if (tail.hit)
                tail_status = kdt_pkg::ST_UPDATED;
            else if (tail.appended)
                tail_status = kdt_pkg::ST_ADDED;
            else
                tail_status = kdt_pkg::ST_FULL;
        end
        else
        begin
            tail_status = tail.hit ? kdt_pkg::ST_FOUND : kdt_pkg::ST_NOT_FOUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            count_reg      <= '0;
            done_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
                busy_reg <= 1'b1;
            else if (move_out)
                busy_reg <= 1'b0;

            if (tail.valid)
                count_reg <= count_next;

            // Hold the finished request until the output register frees up.
            if (tail.valid)
                done_valid_reg <= 1'b1;
            else if (move_out)
                done_valid_reg <= 1'b0;

            if (move_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.valid)
        begin
            done_status_reg <= tail_status;
            done_found_reg  <= tail_found;
            done_count_reg  <= tail_count;
        end
        if (move_out)
        begin
            out_status_reg <= done_status_reg;
            out_found_reg  <= done_found_reg;
            out_count_reg  <= done_count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign found_handle = out_found_reg;
    assign entry_count  = out_count_reg;

    `KDT_ASSERT(a_busy_after_accept, accept |=> busy_reg, "busy not set after accept")
    `KDT_ASSERT(a_count_bound, count_reg <= CNT_BITS'(DEPTH), "entry count above depth")
    `KDT_ASSERT_NEVER(a_done_overrun, tail.valid && done_valid_reg,
        "chain result overwrites a held result")
    `KDT_ASSERT(a_count_step,
        (count_reg != $past(count_reg)) |-> $past(tail.valid && tail.appended),
        "entry count changed without an append")

endmodule

`default_nettype wire
